### design/skt_pkg.sv
package skt_pkg;

  // Operation codes carried on the action field.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

  // Fixed widths of the word fields.
  localparam int unsigned KeyW   = 32;
  localparam int unsigned IndexW = 6;
  localparam int unsigned CountW = 7;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_PUT0,
    ST_SRCH,
    ST_DEL
  } state_e;

endpackage

### design/skt_key_ram.sv
module skt_key_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [AddrW-1:0]                    waddr_i,
  input  logic signed [skt_pkg::KeyW-1:0]     wdata_i,
  input  logic                                re_i,
  input  logic [AddrW-1:0]                    raddr_i,
  output logic signed [skt_pkg::KeyW-1:0]     rdata_o
);

  logic signed [skt_pkg::KeyW-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/sorted_key_table_core.sv
// Insert walks from the tail, moving each smaller-or-equal key down one entry at a time through
// the key RAM, unless the table is empty or full; search walks from index 0 up to the tail;
// delete walks from index + 1 to the tail, unless the index is bad or the last. The result is
// registered in the pending register and then moves on to the output register. A new word is
// taken only while the sequencer is idle and the pending register is empty.
// Reset clears the entry count, the sequencer and the valid flags of both result registers.
module sorted_key_table_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            action_i,
  input  logic signed [skt_pkg::KeyW-1:0]       key_i,
  input  logic [skt_pkg::IndexW-1:0]            entry_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            status_o,
  output logic [skt_pkg::IndexW-1:0]            found_index_o,
  output logic [skt_pkg::CountW-1:0]            entry_count_o
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CmpW = (CW > skt_pkg::IndexW) ? CW : skt_pkg::IndexW;

  skt_pkg::state_e state_q, state_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic signed [skt_pkg::KeyW-1:0] key_q, key_d;

  // RAM port controls.
  logic                            ram_we, ram_re;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  logic signed [skt_pkg::KeyW-1:0] ram_wdata, ram_rdata;

  // Pending result and output register.
  logic                         res_load;
  logic [1:0]                   res_status;
  logic [AW-1:0]                res_index;
  logic                         pend_valid_q;
  logic [1:0]                   pend_status_q;
  logic [skt_pkg::IndexW-1:0]   pend_index_q;
  logic [skt_pkg::CountW-1:0]   pend_count_q;
  logic                         out_valid_q;
  logic [1:0]                   out_status_q;
  logic [skt_pkg::IndexW-1:0]   out_index_q;
  logic [skt_pkg::CountW-1:0]   out_count_q;
  logic                         move_out;

  logic          accept;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] pos_idx;
  logic          pos_bad;

  skt_key_ram #(
    .Depth (TABLE_DEPTH),
    .AddrW (AW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == skt_pkg::ST_IDLE) && !pend_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign last_idx   = AW'(cnt_q - CW'(1));
  assign pos_idx    = AW'(entry_index_i);
  assign pos_bad    = CmpW'(entry_index_i) >= CmpW'(cnt_q);
  assign move_out   = pend_valid_q && (!out_valid_q || out_ready_i);

  // Sequencer: walks the key RAM one entry per cycle, reading ahead of its writes.
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    key_d      = key_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = key_q;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    res_load   = 1'b0;
    res_status = skt_pkg::STAT_OK;
    res_index  = '0;

    unique case (state_q)
      skt_pkg::ST_IDLE: begin
        if (accept) begin
          key_d = key_i;
          unique case (action_i)
            skt_pkg::ACT_INSERT: begin
              if (cnt_q == CW'(TABLE_DEPTH)) begin
                res_load   = 1'b1;
                res_status = skt_pkg::STAT_FULL;
              end else if (cnt_q == '0) begin
                ram_we    = 1'b1;
                ram_wdata = key_i;
                cnt_d     = CW'(1);
                res_load  = 1'b1;
              end else begin
                // Start at the tail and move smaller-or-equal keys down.
                ram_re    = 1'b1;
                ram_raddr = last_idx;
                ptr_d     = last_idx;
                state_d   = skt_pkg::ST_INS_SCAN;
              end
            end
            skt_pkg::ACT_SEARCH: begin
              if (cnt_q == '0) begin
                res_load   = 1'b1;
                res_status = skt_pkg::STAT_NOT_FOUND;
              end else begin
                ram_re  = 1'b1;
                ptr_d   = '0;
                state_d = skt_pkg::ST_SRCH;
              end
            end
            skt_pkg::ACT_DELETE: begin
              if (pos_bad) begin
                res_load   = 1'b1;
                res_status = skt_pkg::STAT_BAD_INDEX;
              end else if (pos_idx == last_idx) begin
                cnt_d    = cnt_q - CW'(1);
                res_load = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = pos_idx + AW'(1);
                ptr_d     = pos_idx + AW'(1);
                state_d   = skt_pkg::ST_DEL;
              end
            end
            default: begin
              res_load   = 1'b1;
              res_status = skt_pkg::STAT_BAD_INDEX;
            end
          endcase
        end
      end

      skt_pkg::ST_INS_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q + AW'(1);
        if (ram_rdata > key_q) begin
          // The new key lands just after the last larger key.
          ram_wdata = key_q;
          cnt_d     = cnt_q + CW'(1);
          res_load  = 1'b1;
          res_index = ptr_q + AW'(1);
          state_d   = skt_pkg::ST_IDLE;
        end else begin
          ram_wdata = ram_rdata;
          if (ptr_q == '0) begin
            state_d = skt_pkg::ST_INS_PUT0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q - AW'(1);
            ptr_d     = ptr_q - AW'(1);
          end
        end
      end

      skt_pkg::ST_INS_PUT0: begin
        ram_we    = 1'b1;
        ram_wdata = key_q;
        cnt_d     = cnt_q + CW'(1);
        res_load  = 1'b1;
        state_d   = skt_pkg::ST_IDLE;
      end

      skt_pkg::ST_SRCH: begin
        if (ram_rdata == key_q) begin
          res_load  = 1'b1;
          res_index = ptr_q;
          state_d   = skt_pkg::ST_IDLE;
        end else if (ptr_q == last_idx) begin
          res_load   = 1'b1;
          res_status = skt_pkg::STAT_NOT_FOUND;
          state_d    = skt_pkg::ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end

      skt_pkg::ST_DEL: begin
        // Move each entry one place up to close the gap.
        ram_we    = 1'b1;
        ram_waddr = ptr_q - AW'(1);
        ram_wdata = ram_rdata;
        if (ptr_q == last_idx) begin
          cnt_d    = cnt_q - CW'(1);
          res_load = 1'b1;
          state_d  = skt_pkg::ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end

      default: begin
        state_d = skt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skt_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Operation payload.
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    key_q <= key_d;
  end

  // Pending result holds a finished word until the output register frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (res_load) begin
      pend_valid_q <= 1'b1;
    end else if (move_out) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      pend_status_q <= res_status;
      pend_index_q  <= skt_pkg::IndexW'(res_index);
      pend_count_q  <= skt_pkg::CountW'(cnt_d);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_out) begin
      out_status_q <= pend_status_q;
      out_index_q  <= pend_index_q;
      out_count_q  <= pend_count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_index_o = out_index_q;
  assign entry_count_o = out_count_q;

endmodule

### tb/tb_top.sv
module tb_top;

  localparam int TableDepth = 64;
  localparam int CycleLimit = 1000000;
  localparam int TailCycles = 80;

  // Action code that no operation uses.
  localparam logic [1:0] ActReserved = 2'd3;

  // One expected result word.
  typedef struct packed {
    logic [1:0]                 status;
    logic [skt_pkg::IndexW-1:0] found_idx;
    logic [skt_pkg::CountW-1:0] count;
  } table_result_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready_o;
  logic [1:0]                        action;
  logic signed [skt_pkg::KeyW-1:0]   key;
  logic [skt_pkg::IndexW-1:0]        entry_index;
  logic                              out_valid_o;
  logic                              out_ready;
  logic [1:0]                        status_o;
  logic [skt_pkg::IndexW-1:0]        found_index_o;
  logic [skt_pkg::CountW-1:0]        entry_count_o;

  // Shadow copy of the table, kept in step with accepted words.
  logic signed [skt_pkg::KeyW-1:0]   shadow_keys [TableDepth];
  int                                shadow_count;
  table_result_t                     pending_results [$];

  int fail_count;
  int cycle_count;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_cycles;

  sorted_key_table_core #(
    .TABLE_DEPTH(TableDepth)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .action_i       (action),
    .key_i          (key),
    .entry_index_i  (entry_index),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .found_index_o  (found_index_o),
    .entry_count_o  (entry_count_o)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: a long hold-off when requested, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Applies one operation to the shadow table and returns the result it causes.
  function automatic table_result_t table_predict(input logic [1:0] act,
                                                  input logic signed [skt_pkg::KeyW-1:0] k,
                                                  input logic [skt_pkg::IndexW-1:0] idx);
    table_result_t r;
    int            at;
    int            i;
    logic          hit;
    r.status    = skt_pkg::STAT_BAD_INDEX;
    r.found_idx = '0;
    hit         = 1'b0;
    case (act)
      skt_pkg::ACT_INSERT: begin
        if (shadow_count >= TableDepth) begin
          r.status = skt_pkg::STAT_FULL;
        end else begin
          at = 0;
          while (at < shadow_count && shadow_keys[at] > k) at++;
          for (i = shadow_count; i > at; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[at] = k;
          shadow_count++;
          r.status    = skt_pkg::STAT_OK;
          r.found_idx = skt_pkg::IndexW'(at);
        end
      end
      skt_pkg::ACT_SEARCH: begin
        r.status = skt_pkg::STAT_NOT_FOUND;
        for (i = 0; i < shadow_count; i++) begin
          if (!hit && shadow_keys[i] == k) begin
            hit         = 1'b1;
            r.status    = skt_pkg::STAT_OK;
            r.found_idx = skt_pkg::IndexW'(i);
          end
        end
      end
      skt_pkg::ACT_DELETE: begin
        if (int'(idx) < shadow_count) begin
          for (i = int'(idx); i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
          shadow_count--;
          r.status = skt_pkg::STAT_OK;
        end
      end
      default: begin
        r.status = skt_pkg::STAT_BAD_INDEX;
      end
    endcase
    r.count = skt_pkg::CountW'(shadow_count);
    return r;
  endfunction

  // Key mix: extremes, a narrow band that makes duplicates, stored keys, full range.
  function automatic logic signed [skt_pkg::KeyW-1:0] pick_key();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3, 4: return int'($urandom_range(16)) - 8;
      5: begin
        if (shadow_count > 0) return shadow_keys[$urandom_range(shadow_count - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  // Offers one word after an optional random gap; returns at the accepting edge.
  task automatic send_word(input logic [1:0] act, input logic signed [skt_pkg::KeyW-1:0] k,
                           input logic [skt_pkg::IndexW-1:0] idx);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    key         <= k;
    entry_index <= idx;
    // Inputs and state are settled mid-cycle, so ready seen here holds at the next edge.
    do begin
      @(negedge clk);
    end while (!in_ready_o);
    pending_results.push_back(table_predict(act, k, idx));
    @(posedge clk);
  endtask

  // Stops offering words and waits for every expected result.
  task automatic wait_all_results(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Scoreboard: an output word is taken at the next edge whenever valid and ready
  // are both high at the falling edge.
  always @(negedge clk) begin : check_result
    table_result_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d found_index %0d entry_count %0d",
               status_o, found_index_o, entry_count_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
        if (found_index_o !== want.found_idx) begin
          $error("found_index: expected %0d, actual %0d", want.found_idx, found_index_o);
          fail_count++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, entry_count_o);
          fail_count++;
        end
      end
    end
  end

  // Empty-table cases, key extremes, duplicates, hits, misses and bad indexes.
  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_word(skt_pkg::ACT_SEARCH, 32'sd0, 6'd0);
    send_word(skt_pkg::ACT_DELETE, 32'sd0, 6'd0);
    send_word(ActReserved, 32'sd0, 6'd0);
    send_word(skt_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 6'd63);
    send_word(skt_pkg::ACT_INSERT, 32'sh8000_0000, 6'd0);
    send_word(skt_pkg::ACT_INSERT, 32'sd0, 6'd0);
    send_word(skt_pkg::ACT_INSERT, -32'sd1, 6'd0);
    send_word(skt_pkg::ACT_INSERT, 32'sd5, 6'd0);
    send_word(skt_pkg::ACT_INSERT, 32'sd5, 6'd0);
    send_word(skt_pkg::ACT_SEARCH, 32'sd5, 6'd63);
    send_word(skt_pkg::ACT_SEARCH, 32'sh8000_0000, 6'd0);
    send_word(skt_pkg::ACT_SEARCH, 32'sh7FFF_FFFF, 6'd0);
    send_word(skt_pkg::ACT_SEARCH, 32'sd7, 6'd0);
    send_word(ActReserved, 32'shFFFF_FFFF, 6'd63);
    send_word(skt_pkg::ACT_DELETE, 32'shFFFF_FFFF, 6'd63);
    send_word(skt_pkg::ACT_DELETE, 32'sd0, 6'd6);
    send_word(skt_pkg::ACT_DELETE, 32'sd0, 6'd5);
    send_word(skt_pkg::ACT_DELETE, 32'sd0, 6'd0);
    send_word(skt_pkg::ACT_DELETE, 32'sd0, 6'd1);
    send_word(skt_pkg::ACT_SEARCH, 32'sd5, 6'd0);
    send_word(skt_pkg::ACT_SEARCH, 32'sd0, 6'd0);
    wait_all_results(4);
  endtask

  // Fills the table, probes the full case and the last index, then empties it.
  task automatic test_table_full();
    tx_idle_pct  = 30;
    rx_stall_pct = 30;
    while (shadow_count < TableDepth) begin
      send_word(skt_pkg::ACT_INSERT, pick_key(), skt_pkg::IndexW'($urandom));
    end
    send_word(skt_pkg::ACT_INSERT, pick_key(), 6'd0);
    send_word(skt_pkg::ACT_INSERT, 32'sh8000_0000, 6'd0);
    send_word(skt_pkg::ACT_SEARCH, shadow_keys[TableDepth-1], 6'd0);
    send_word(skt_pkg::ACT_DELETE, 32'sd0, 6'd63);
    send_word(skt_pkg::ACT_INSERT, 32'sh8000_0000, 6'd0);
    send_word(skt_pkg::ACT_DELETE, 32'sd0, 6'd0);
    while (shadow_count > 0) begin
      send_word(skt_pkg::ACT_DELETE, $urandom,
                skt_pkg::IndexW'($urandom_range(shadow_count - 1)));
    end
    send_word(skt_pkg::ACT_DELETE, 32'sd0, 6'd0);
    wait_all_results(4);
  endtask

  // Random words in alternating fill and drain stretches so the count sweeps its range.
  task automatic test_random(input int n_words, input int tx_pct, input int rx_pct);
    int                         sent;
    int                         stretch;
    logic                       filling;
    int                         roll;
    logic [1:0]                 act;
    logic [skt_pkg::IndexW-1:0] idx;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    filling      = 1'b1;
    stretch      = $urandom_range(90, 30);
    for (sent = 0; sent < n_words; sent++) begin
      if (stretch == 0) begin
        filling = ~filling;
        stretch = $urandom_range(90, 30);
      end
      stretch--;
      roll = $urandom_range(99);
      if (filling) begin
        act = (roll < 60) ? skt_pkg::ACT_INSERT : (roll < 80) ? skt_pkg::ACT_SEARCH :
              (roll < 97) ? skt_pkg::ACT_DELETE : ActReserved;
      end else begin
        act = (roll < 20) ? skt_pkg::ACT_INSERT : (roll < 40) ? skt_pkg::ACT_SEARCH :
              (roll < 97) ? skt_pkg::ACT_DELETE : ActReserved;
      end
      if (shadow_count > 0 && $urandom_range(99) < 85) begin
        idx = skt_pkg::IndexW'($urandom_range(shadow_count - 1));
      end else begin
        idx = skt_pkg::IndexW'($urandom);
      end
      send_word(act, pick_key(), idx);
    end
    wait_all_results(4);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering words.
  task automatic test_output_backpressure();
    int i;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(negedge clk);
    hold_cycles = 400;
    @(posedge clk);
    for (i = 0; i < 40; i++) begin
      send_word(($urandom_range(2) == 0) ? skt_pkg::ACT_SEARCH : skt_pkg::ACT_INSERT,
                pick_key(), skt_pkg::IndexW'($urandom));
    end
    wait_all_results(4);
  endtask

  initial begin
    fail_count   = 0;
    cycle_count  = 0;
    hold_cycles  = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    shadow_count = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    action      <= skt_pkg::ACT_INSERT;
    key         <= '0;
    entry_index <= '0;
    out_ready   <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_random(180, 0, 0);
    test_random(180, 60, 0);
    test_random(180, 0, 60);
    test_random(180, 30, 30);
    test_output_backpressure();
    wait_all_results(TailCycles);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
